// ===== rtl/hsd_pkg.sv =====
// Shared types, codes and elaboration-time table builders for the
// half-scale RGBA downsampler. No dependencies.
package hsd_pkg;

    // Configuration port shape
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_WID_W  = 13;
    localparam int CFG_HGT_W  = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_SRGB   = 2'd2
    } hsd_cfg_t;

    // Widest table entries over the supported linear code widths
    localparam int LIN_MAX_W = 16;
    localparam int THR_MAX_W = LIN_MAX_W + 2;

    typedef logic [255:0][LIN_MAX_W-1:0] hsd_lin_tab_t;
    typedef logic [255:0][THR_MAX_W-1:0] hsd_thr_tab_t;

    // One pixel plus its position flags, held in the input register
    typedef struct packed {
        logic [3:0][7:0] px;
        logic            srgb;
        logic            x_odd;
        logic            y_odd;
        logic            x_in;
        logic            y_in;
        logic            x_last;
        logic            y_last;
    } hsd_item_t;

    // Control that travels with a finished 2x2 sum
    typedef struct packed {
        logic srgb;
        logic row_end;
        logic frame_end;
    } hsd_sum_ctl_t;

    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    // sRGB ratios are all expressed over this denominator
    localparam longint unsigned DEC_DEN = 64'd510;

    // Fifth power in Q30, truncating after every multiply
    function automatic longint unsigned fifth_pow(input longint unsigned s);
        longint unsigned p;
        p = s;
        for (int k = 0; k < 4; k++)
            p = (p * s) >> 30;
        return p;
    endfunction

    // Largest Q30 value whose truncated fifth power does not exceed t
    function automatic longint unsigned fifth_root(input longint unsigned t);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = Q30_ONE;
        for (int i = 0; i < 34; i++)
        begin
            if (lo < hi)
            begin
                mid = lo + ((hi - lo + 1) >> 1);
                if (fifth_pow(mid) <= t)
                    lo = mid;
                else
                    hi = mid - 1;
            end
        end
        return lo;
    endfunction

    // Linear light in Q30 of the sRGB value num/510
    function automatic longint unsigned decode_q30(input longint unsigned num);
        longint unsigned t;
        longint unsigned s;
        longint unsigned t2;
        longint unsigned s2;
        if (100000 * num <= 4045 * DEC_DEN)
            return (100 * num * Q30_ONE + 646 * DEC_DEN) / (1292 * DEC_DEN);
        t  = (((1000 * num + 55 * DEC_DEN) << 30) + (1055 * DEC_DEN) / 2)
             / (1055 * DEC_DEN);
        s  = fifth_root(t);
        t2 = (t * t) >> 30;
        s2 = (s * s) >> 30;
        return (t2 * s2) >> 30;
    endfunction

    // Byte to linear code table (byte/255 is the same as 2*byte/510)
    function automatic hsd_lin_tab_t build_lin(input int lbits);
        hsd_lin_tab_t    tab;
        longint unsigned lmax;
        lmax = (64'd1 << lbits) - 1;
        for (int b = 0; b < 256; b++)
            tab[b] = LIN_MAX_W'((decode_q30(longint'(2 * b)) * lmax
                                 + (Q30_ONE >> 1)) >> 30);
        return tab;
    endfunction

    // Smallest four-code sum that reaches each encode midpoint
    function automatic hsd_thr_tab_t build_thr(input int lbits);
        hsd_thr_tab_t    tab;
        longint unsigned scale;
        scale  = 4 * ((64'd1 << lbits) - 1);
        tab[0] = '0;
        for (int k = 1; k < 256; k++)
            tab[k] = THR_MAX_W'((scale * decode_q30(longint'(2 * k - 1))
                                 + Q30_ONE - 1) >> 30);
        return tab;
    endfunction

    // Thermometer (bit k set for every k up to n, bit 256 clear) to n
    function automatic logic [7:0] therm_to_bin(input logic [256:0] th);
        logic [7:0] n;
        int         lo;
        n = '0;
        for (int j = 0; j < 8; j++)
        begin
            for (int m = 0; m < 128; m++)
            begin
                if (m < (128 >> j))
                begin
                    lo = m * (2 << j) + (1 << j);
                    n[j] = n[j] | (th[lo] & ~th[lo + (1 << j)]);
                end
            end
        end
        return n;
    endfunction

endpackage

// ===== rtl/hsd_ifs.sv =====
// Valid/ready stream interfaces for input pixels and output pixels.
// Depends on nothing.
interface hsd_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;

    modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
    modport sink   (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface hsd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       row_end;
    logic       frame_end;

    modport source (output valid, out_red, out_green, out_blue, out_alpha,
                    row_end, frame_end, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_alpha,
                    row_end, frame_end, output ready);
endinterface

// ===== rtl/hsd_front.sv =====
// Input register, configuration registers and raster position counters.
// Depends on hsd_pkg and hsd_pix_if.
module hsd_front
    import hsd_pkg::*;
#(
    parameter  int MAX_WIDTH = 4096,
    localparam int SLOTS     = (MAX_WIDTH + 1) / 2,
    localparam int AW        = (SLOTS > 1) ? $clog2(SLOTS) : 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    hsd_pix_if.sink               pix,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  rd_en,
    output logic [AW-1:0]         rd_addr,
    output logic                  item_valid,
    output hsd_item_t             item,
    output logic [AW-1:0]         item_slot,
    input  logic                  item_take
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int EW = (CW + 1 > CFG_WID_W) ? CW + 1 : CFG_WID_W;

    logic [CFG_WID_W-1:0] width_reg;
    logic [CFG_HGT_W-1:0] height_reg;
    logic                 srgb_reg;
    logic [CW-1:0]        col_reg;
    logic [CW-1:0]        col_next;
    logic [CFG_HGT_W-1:0] row_reg;
    logic [CFG_HGT_W-1:0] row_next;
    logic                 item_valid_reg;
    hsd_item_t            item_reg;
    hsd_item_t            item_next;
    logic [AW-1:0]        slot_reg;

    logic                 accept;
    logic [EW-1:0]        w_ext;
    logic [EW-1:0]        w_eff;
    logic [EW-1:0]        last_x;
    logic [EW-1:0]        x_ext;
    logic [CFG_HGT_W-1:0] h_eff;
    logic [CFG_HGT_W-1:0] last_y;
    logic                 x_wrap;
    logic                 y_wrap;

    // Take a new item whenever the input register is empty or draining
    assign pix.ready = !item_valid_reg || item_take;
    assign accept    = pix.valid && pix.ready;

    // Effective frame size and the last complete pair column and row
    always_comb
    begin
        w_ext = EW'(width_reg);
        if (w_ext < EW'(2))
            w_eff = EW'(2);
        else if (w_ext > EW'(MAX_WIDTH))
            w_eff = EW'(MAX_WIDTH);
        else
            w_eff = w_ext;
        last_x = (w_eff & ~EW'(1)) - EW'(1);
        x_ext  = EW'(col_reg);
        x_wrap = x_ext >= w_eff - EW'(1);

        h_eff  = (height_reg < CFG_HGT_W'(2)) ? CFG_HGT_W'(2) : height_reg;
        last_y = {h_eff[CFG_HGT_W-1:1], 1'b0} - CFG_HGT_W'(1);
        y_wrap = row_reg >= h_eff - CFG_HGT_W'(1);
    end

    // Position flags and next counter values for the pixel at the port
    always_comb
    begin
        item_next.px     = {pix.in_alpha, pix.in_blue, pix.in_green, pix.in_red};
        item_next.srgb   = srgb_reg;
        item_next.x_odd  = col_reg[0];
        item_next.y_odd  = row_reg[0];
        item_next.x_in   = x_ext <= last_x;
        item_next.y_in   = row_reg <= last_y;
        item_next.x_last = x_ext == last_x;
        item_next.y_last = row_reg == last_y;

        if (x_wrap)
        begin
            col_next = '0;
            row_next = y_wrap ? '0 : row_reg + CFG_HGT_W'(1);
        end
        else
        begin
            col_next = col_reg + CW'(1);
            row_next = row_reg;
        end
    end

    // Line buffer read goes out with the accept so data lines up with the item
    assign rd_en   = accept;
    assign rd_addr = AW'(col_reg >> 1);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_WID_W'(2);
            height_reg <= CFG_HGT_W'(2);
            srgb_reg   <= 1'b0;
        end
        else if (cfg_wen)
        begin
            unique case (hsd_cfg_t'(cfg_index))
                CFG_WIDTH:  width_reg  <= cfg_data[CFG_WID_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[CFG_HGT_W-1:0];
                CFG_SRGB:   srgb_reg   <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Advance counters and track the input register occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (accept)
                item_valid_reg <= 1'b1;
            else if (item_take)
                item_valid_reg <= 1'b0;
        end
    end

    // Hold the item payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
            slot_reg <= rd_addr;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;
    assign item_slot  = slot_reg;

endmodule

// ===== rtl/hsd_accum.sv =====
// Decode to linear codes, horizontal pair sums, line buffer and 2x2 sum
// register. Depends on hsd_pkg.
module hsd_accum
    import hsd_pkg::*;
#(
    parameter  int MAX_WIDTH   = 4096,
    parameter  int LINEAR_BITS = 12,
    localparam int SLOTS       = (MAX_WIDTH + 1) / 2,
    localparam int AW          = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int SW          = LINEAR_BITS + 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    input  logic                 item_valid,
    input  hsd_item_t            item,
    input  logic [AW-1:0]        item_slot,
    output logic                 item_take,
    output logic                 sum_valid,
    output hsd_sum_ctl_t         sum_ctl,
    output logic [3:0][SW-1:0]   sum_total,
    input  logic                 sum_ready
);

    localparam int LB = LINEAR_BITS;
    localparam int PW = LINEAR_BITS + 1;
    localparam hsd_lin_tab_t LIN_TAB = build_lin(LINEAR_BITS);

    logic [3:0][PW-1:0] line_mem [SLOTS];
    logic [3:0][PW-1:0] rd_data_reg;
    logic [3:0][LB-1:0] hold_reg;
    logic               sum_valid_reg;
    hsd_sum_ctl_t       ctl_reg;
    logic [3:0][SW-1:0] total_reg;

    logic [3:0][LB-1:0] lin;
    logic [3:0][PW-1:0] pair;
    logic [3:0][SW-1:0] total;
    logic               emit;
    logic               wr_en;

    // Move the item on when the sum register is free or being emptied
    assign item_take = item_valid && (!sum_valid_reg || sum_ready);
    assign emit  = item.x_odd && item.x_in && item.y_odd && item.y_in;
    assign wr_en = item_take && item.x_odd && item.x_in && !item.y_odd;

    // Per channel: decode (sRGB mode only), add to held left pixel, add the row above
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            lin[c]   = item.srgb ? LIN_TAB[item.px[c]][LB-1:0] : LB'(item.px[c]);
            pair[c]  = PW'(hold_reg[c]) + PW'(lin[c]);
            total[c] = SW'(rd_data_reg[c]) + SW'(pair[c]);
        end
    end

    // Line buffer: pair sums of the even row, one entry per output column
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= line_mem[rd_addr];
        if (wr_en)
            line_mem[item_slot] <= pair;
    end

    // Hold the even-column pixel for the next pair
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_reg <= '0;
        else if (item_take && !item.x_odd)
            hold_reg <= lin;
    end

    // Sum register occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_valid_reg <= 1'b0;
        else if (item_take)
            sum_valid_reg <= emit;
        else if (sum_ready)
            sum_valid_reg <= 1'b0;
    end

    // Capture a finished block
    always_ff @(posedge clk)
    begin
        if (item_take && emit)
        begin
            total_reg         <= total;
            ctl_reg.srgb      <= item.srgb;
            ctl_reg.row_end   <= item.x_last;
            ctl_reg.frame_end <= item.x_last && item.y_last;
        end
    end

    assign sum_valid = sum_valid_reg;
    assign sum_ctl   = ctl_reg;
    assign sum_total = total_reg;

endmodule

// ===== rtl/hsd_encode.sv =====
// Mean of four codes back to bytes (sRGB threshold search or plain shift)
// and the output register. Depends on hsd_pkg and hsd_res_if.
module hsd_encode
    import hsd_pkg::*;
#(
    parameter  int LINEAR_BITS = 12,
    localparam int SW          = LINEAR_BITS + 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sum_valid,
    input  hsd_sum_ctl_t       sum_ctl,
    input  logic [3:0][SW-1:0] sum_total,
    output logic               sum_ready,
    hsd_res_if.source          res
);

    localparam int LB = LINEAR_BITS;
    localparam hsd_thr_tab_t THR_TAB = build_thr(LINEAR_BITS);

    logic [3:0][256:0] therm;
    logic [3:0][7:0]   byte_val;
    logic [LB-1:0]     mean;
    logic              out_valid_reg;
    logic [3:0][7:0]   out_px_reg;
    logic              row_end_reg;
    logic              frame_end_reg;

    assign sum_ready = !out_valid_reg || res.ready;

    // Compare each sum against every midpoint, then read off the count
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            therm[c][0]   = 1'b1;
            therm[c][256] = 1'b0;
            for (int k = 1; k < 256; k++)
                therm[c][k] = sum_total[c] >= THR_TAB[k][SW-1:0];
        end
    end

    always_comb
    begin
        mean = '0;
        for (int c = 0; c < 4; c++)
        begin
            mean = sum_total[c][SW-1:2];
            if (sum_ctl.srgb)
                byte_val[c] = therm_to_bin(therm[c]);
            else if (mean > LB'(255))
                byte_val[c] = 8'hFF;
            else
                byte_val[c] = mean[7:0];
        end
    end

    // Output register occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (sum_ready)
            out_valid_reg <= sum_valid;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (sum_ready && sum_valid)
        begin
            out_px_reg    <= byte_val;
            row_end_reg   <= sum_ctl.row_end;
            frame_end_reg <= sum_ctl.frame_end;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.out_red   = out_px_reg[0];
    assign res.out_green = out_px_reg[1];
    assign res.out_blue  = out_px_reg[2];
    assign res.out_alpha = out_px_reg[3];
    assign res.row_end   = row_end_reg;
    assign res.frame_end = frame_end_reg;

endmodule

// ===== rtl/half_scale_rgba_downsampler.sv =====
// Top level of the half-scale RGBA downsampler: 2x2 box filter, plain or
// sRGB-correct. Depends on hsd_pkg, hsd_ifs, hsd_front, hsd_accum, hsd_encode.
//
//  port        kind         per item
//  ----------  -----------  -------------------------------------------------
//  pix         stream in    in_red, in_green, in_blue, in_alpha (8 bits each)
//  res         stream out   out_red..out_alpha (8 bits), row_end, frame_end
//  cfg_*       write only   0 image_width, 1 image_height, 2 srgb_mode
//
// One pixel is taken every clock while res is not stalled; a result is valid once
// the pixel completing its 2x2 block has passed the input, sum and output registers.
// The line buffer read is issued with the accept and the write lands when the item
// leaves the input register, which is what fixes the one-pixel-per-clock rate.
// Stalls on res back up through the three registers to pix.ready.
// Reset clears counters, held pixel and registers; the line buffer is not
// cleared and every entry is written on an even row before it is read.
module half_scale_rgba_downsampler
    import hsd_pkg::*;
#(
    parameter int MAX_WIDTH   = 4096,
    parameter int LINEAR_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    hsd_pix_if.sink               pix,
    hsd_res_if.source             res,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SLOTS = (MAX_WIDTH + 1) / 2;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SW    = LINEAR_BITS + 2;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               item_valid;
    hsd_item_t          item;
    logic [AW-1:0]      item_slot;
    logic               item_take;
    logic               sum_valid;
    hsd_sum_ctl_t       sum_ctl;
    logic [3:0][SW-1:0] sum_total;
    logic               sum_ready;

    // Position tracking and input register
    hsd_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .item_valid (item_valid),
        .item       (item),
        .item_slot  (item_slot),
        .item_take  (item_take)
    );

    // Decode, pair and block sums with the line buffer
    hsd_accum #(
        .MAX_WIDTH   (MAX_WIDTH),
        .LINEAR_BITS (LINEAR_BITS)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .item_valid (item_valid),
        .item       (item),
        .item_slot  (item_slot),
        .item_take  (item_take),
        .sum_valid  (sum_valid),
        .sum_ctl    (sum_ctl),
        .sum_total  (sum_total),
        .sum_ready  (sum_ready)
    );

    // Re-encode and output register
    hsd_encode #(
        .LINEAR_BITS (LINEAR_BITS)
    ) u_encode (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum_valid (sum_valid),
        .sum_ctl   (sum_ctl),
        .sum_total (sum_total),
        .sum_ready (sum_ready),
        .res       (res)
    );

`ifndef ASSERT_OFF
    // The last pixel of a frame is also the last of its row
    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.row_end || !res.frame_end))
        else $error("frame_end without row_end");

    // A held item never waits while the sum register is empty
    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !sum_valid) |-> item_take)
        else $error("item held with free sum register");

    // A block sum only appears when an item moved out of the input register
    a_sum_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sum_valid) |-> $past(item_take))
        else $error("sum register filled without an item");

    // A result only appears from a pending block sum
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(sum_valid))
        else $error("result without a block sum");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for half_scale_rgba_downsampler: a directed table of pixels and
// register writes, then random frames and mid-frame reconfiguration, all scored
// against a 2x2 box filter predictor. Depends on hsd_pkg, hsd_ifs and the block RTL.
module tb_top
    import hsd_pkg::*;
();

    localparam int MAX_W = 4096;
    localparam int LIN_BITS = 12;
    localparam int LINE_SLOTS = MAX_W / 2;
    localparam int unsigned LIN_MAX = (1 << LIN_BITS) - 1;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam int CLK_PERIOD = 10;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 550;
    localparam int SHOWN_MISMATCHES = 10;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } rgba_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       row_end;
        logic       frame_end;
    } half_px_t;

    typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        hsd_cfg_t               reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        rgba_t                  px;
        bit                     typed;
        half_px_t               want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hsd_pix_if pix_ch ();
    hsd_res_if res_ch ();

    // Predictor copy of registers, counters, held pixel and line sums
    int unsigned     lin_code [256];
    longint unsigned enc_thresh [256];
    int unsigned     width_reg;
    int unsigned     height_reg;
    bit              srgb_reg;
    int unsigned     next_col;
    int unsigned     next_row;
    int unsigned     held_px [4];
    int unsigned     line_pairs [LINE_SLOTS][4];

    half_px_t  expected_px [$];
    stim_row_t directed_rows [$];
    half_px_t  seen_px;
    half_px_t  want_px;
    int        mismatches = 0;
    int        cycles = 0;
    int        stall_left = 0;
    int        seg_left = 0;
    bit        seg_quiet = 1'b0;

    half_scale_rgba_downsampler #(
        .MAX_WIDTH   (MAX_W),
        .LINEAR_BITS (LIN_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix_ch),
        .res       (res_ch),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Linear light in Q30 of the sRGB value num/den
    function automatic longint unsigned srgb_to_lin_q30(input longint unsigned num,
                                                        input longint unsigned den);
        longint unsigned t;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned p;
        if (100000 * num <= 4045 * den)
            return (100 * num * ONE_Q30 + 646 * den) / (1292 * den);
        t = (((1000 * num + 55 * den) << 30) + (1055 * den) / 2) / (1055 * den);
        // bisect for the fifth root, truncating the power after each multiply
        lo = 0;
        hi = ONE_Q30;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            p = mid;
            repeat (4) p = (p * mid) >> 30;
            if (p <= t)
                lo = mid;
            else
                hi = mid - 1;
        end
        return (((t * t) >> 30) * ((lo * lo) >> 30)) >> 30;
    endfunction

    // Advance the predictor by one pixel; returns 1 when a 2x2 block completes
    function automatic bit downsample_step(input rgba_t px, output half_px_t res);
        int unsigned     w;
        int unsigned     h;
        int unsigned     last_x;
        int unsigned     last_y;
        int unsigned     slot;
        int unsigned     total;
        int unsigned     n;
        longint unsigned lhs;
        int unsigned     chan [4];
        int unsigned     pair [4];
        logic [7:0]      avg [4];
        bit              got;
        got = 1'b0;
        res = '0;
        w = width_reg;
        h = height_reg;
        if (w < 2)
            w = 2;
        if (w > MAX_W)
            w = MAX_W;
        if (h < 2)
            h = 2;
        last_x = (w & 32'hFFFF_FFFE) - 1;
        last_y = (h & 32'hFFFF_FFFE) - 1;
        chan[0] = px.red;
        chan[1] = px.green;
        chan[2] = px.blue;
        chan[3] = px.alpha;
        for (int c = 0; c < 4; c++)
            if (srgb_reg)
                chan[c] = lin_code[chan[c]];

        if ((next_col & 1) == 0)
        begin
            for (int c = 0; c < 4; c++)
                held_px[c] = chan[c];
        end
        else if (next_col <= last_x)
        begin
            slot = next_col >> 1;
            for (int c = 0; c < 4; c++)
                pair[c] = held_px[c] + chan[c];
            if ((next_row & 1) == 0)
            begin
                for (int c = 0; c < 4; c++)
                    line_pairs[slot][c] = pair[c];
            end
            else if (next_row <= last_y)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    total = line_pairs[slot][c] + pair[c];
                    if (srgb_reg)
                    begin
                        // count encode midpoints reached by the four-code sum
                        lhs = total;
                        lhs = lhs << 30;
                        n = 0;
                        for (int k = 1; k < 256; k++)
                            if (lhs >= 4 * longint'(LIN_MAX) * enc_thresh[k])
                                n++;
                        avg[c] = n[7:0];
                    end
                    else
                    begin
                        n = total >> 2;
                        avg[c] = (n > 255) ? 8'hFF : n[7:0];
                    end
                end
                res.red = avg[0];
                res.green = avg[1];
                res.blue = avg[2];
                res.alpha = avg[3];
                res.row_end = (next_col == last_x);
                res.frame_end = (next_col == last_x) && (next_row == last_y);
                got = 1'b1;
            end
        end

        // wrap as soon as the counter reaches or passes the last column or row
        if (next_col >= w - 1)
        begin
            next_col = 0;
            next_row = (next_row >= h - 1) ? 0 : next_row + 1;
        end
        else
            next_col++;
        return got;
    endfunction

    function automatic void add_pix(input rgba_t px, input bit typed, input half_px_t want);
        stim_row_t row;
        row.kind = ROW_PIX;
        row.reg_idx = CFG_WIDTH;
        row.reg_val = '0;
        row.px = px;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input hsd_cfg_t idx, input logic [CFG_DATA_W-1:0] val);
        stim_row_t row;
        row.kind = ROW_CFG;
        row.reg_idx = idx;
        row.reg_val = val;
        row.px = '0;
        row.typed = 1'b0;
        row.want = '0;
        directed_rows.push_back(row);
    endfunction

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one pixel, hold it until accepted, then queue its expected result
    task automatic send_pixel(input rgba_t px, input int gap, input bit typed,
                              input half_px_t typed_res);
        half_px_t res;
        bit       got;
        if (gap > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.in_red <= px.red;
        pix_ch.in_green <= px.green;
        pix_ch.in_blue <= px.blue;
        pix_ch.in_alpha <= px.alpha;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        got = downsample_step(px, res);
        if (got)
            expected_px.push_back(typed ? typed_res : res);
    endtask

    // Drop valid, wait out every expected result, then let the pipeline empty
    task automatic settle_block();
        pix_ch.valid <= 1'b0;
        while (expected_px.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input hsd_cfg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wen <= 1'b0;
        case (idx)
            CFG_WIDTH:  width_reg = val[CFG_WID_W-1:0];
            CFG_HEIGHT: height_reg = val[CFG_HGT_W-1:0];
            CFG_SRGB:   srgb_reg = val[0];
            default:    ;
        endcase
        @(posedge clk);
    endtask

    // Result sink: segments of random stalls alternate with stall-free stretches
    always @(posedge clk)
    begin
        if (seg_left == 0)
        begin
            seg_left = $urandom_range(50, 300);
            seg_quiet = ($urandom_range(0, 3) == 0);
        end
        seg_left--;
        if (stall_left > 0)
        begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= 1'b1;
            if (!seg_quiet && $urandom_range(0, 3) == 0)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                         : $urandom_range(1, 3);
        end
    end

    // Score each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            seen_px.red = res_ch.out_red;
            seen_px.green = res_ch.out_green;
            seen_px.blue = res_ch.out_blue;
            seen_px.alpha = res_ch.out_alpha;
            seen_px.row_end = res_ch.row_end;
            seen_px.frame_end = res_ch.frame_end;
            if (expected_px.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES)
                    $display("cycle %0d: unexpected result rgba %h %h %h %h row %b frame %b",
                             cycles, seen_px.red, seen_px.green, seen_px.blue,
                             seen_px.alpha, seen_px.row_end, seen_px.frame_end);
            end
            else
            begin
                want_px = expected_px.pop_front();
                if (seen_px.red !== want_px.red || seen_px.green !== want_px.green ||
                    seen_px.blue !== want_px.blue || seen_px.alpha !== want_px.alpha ||
                    seen_px.row_end !== want_px.row_end ||
                    seen_px.frame_end !== want_px.frame_end)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN_MISMATCHES)
                        $display({"cycle %0d: expected rgba %h %h %h %h row %b frame %b,",
                                  " got rgba %h %h %h %h row %b frame %b"},
                                 cycles, want_px.red, want_px.green, want_px.blue,
                                 want_px.alpha, want_px.row_end, want_px.frame_end,
                                 seen_px.red, seen_px.green, seen_px.blue,
                                 seen_px.alpha, seen_px.row_end, seen_px.frame_end);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rgba_t       px;
        logic [7:0]  ch [4];
        logic [2:0]  wmask;
        logic [15:0] val;
        int          random_items;
        int          phase_len;
        int          sent;
        bit          quiet;

        // Hold reset and drive every input to a known value
        rst_n <= 1'b0;
        cfg_wen <= 1'b0;
        cfg_index <= CFG_WIDTH;
        cfg_data <= '0;
        pix_ch.valid <= 1'b0;
        pix_ch.in_red <= '0;
        pix_ch.in_green <= '0;
        pix_ch.in_blue <= '0;
        pix_ch.in_alpha <= '0;

        // Decode and encode tables of the predictor
        for (int b = 0; b < 256; b++)
            lin_code[b] = int'((srgb_to_lin_q30(b, 255) * LIN_MAX + (ONE_Q30 >> 1)) >> 30);
        enc_thresh[0] = 0;
        for (int k = 1; k < 256; k++)
            enc_thresh[k] = srgb_to_lin_q30(2 * k - 1, 510);

        width_reg = 2;
        height_reg = 2;
        srgb_reg = 1'b0;
        next_col = 0;
        next_row = 0;
        for (int c = 0; c < 4; c++)
            held_px[c] = 0;

        // Directed table: reset size, extremes, truncation, sRGB, clamped and odd sizes
        repeat (3) add_pix({8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0, '0);
        add_pix({8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
                {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1});
        add_pix({8'hFF, 8'h00, 8'hFF, 8'h00}, 1'b0, '0);
        add_pix({8'h00, 8'hFF, 8'h00, 8'hFF}, 1'b0, '0);
        add_pix({8'hFF, 8'hFF, 8'h00, 8'h00}, 1'b0, '0);
        add_pix({8'h00, 8'h00, 8'hFF, 8'hFF}, 1'b1,
                {8'h7F, 8'h7F, 8'h7F, 8'h7F, 1'b1, 1'b1});
        add_cfg(CFG_SRGB, 16'd1);
        repeat (3) add_pix({8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0, '0);
        add_pix({8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
                {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1});
        // sizes below two act as two
        add_cfg(CFG_WIDTH, 16'd0);
        add_cfg(CFG_HEIGHT, 16'd1);
        add_cfg(CFG_SRGB, 16'd0);
        repeat (3) add_pix({8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '0);
        add_pix({8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
                {8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1});
        // odd last column and row are dropped
        add_cfg(CFG_WIDTH, 16'd3);
        add_cfg(CFG_HEIGHT, 16'd3);
        for (int i = 0; i < 9; i++)
            add_pix({8'(i * 29), 8'(255 - i * 31), 8'(i * i * 3), 8'(i * 57)}, 1'b0, '0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (int i = 0; i < directed_rows.size(); i++)
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                settle_block();
                cfg_write(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end
            else
                send_pixel(directed_rows[i].px, pick_gap(1'b0), directed_rows[i].typed,
                           directed_rows[i].want);
        end

        // Random phases: reconfigure while idle, often mid-frame, then stream pixels
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            settle_block();
            wmask = 3'($urandom_range(1, 7));
            if (wmask[0])
            begin
                case ($urandom_range(0, 19))
                    17:      val = 16'($urandom_range(0, 1));
                    18:      val = 16'($urandom_range(4095, 4097));
                    19:      val = $urandom_range(0, 1) ? 16'd8191
                                                        : 16'($urandom_range(0, 8191));
                    14, 15, 16: val = 16'($urandom_range(13, 48));
                    default: val = 16'($urandom_range(2, 12));
                endcase
                cfg_write(CFG_WIDTH, val);
            end
            if (wmask[1])
            begin
                case ($urandom_range(0, 19))
                    17:      val = 16'($urandom_range(0, 1));
                    18:      val = 16'hFFFF;
                    19:      val = 16'($urandom_range(0, 65535));
                    14, 15, 16: val = 16'($urandom_range(9, 40));
                    default: val = 16'($urandom_range(2, 8));
                endcase
                cfg_write(CFG_HEIGHT, val);
            end
            if (wmask[2])
                cfg_write(CFG_SRGB, 16'($urandom_range(0, 1)));

            quiet = ($urandom_range(0, 4) == 0);
            phase_len = $urandom_range(16, 64);
            sent = 0;
            // finish on an even row so every line entry read was written this frame
            while (sent < phase_len || (next_row & 1) != 0)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        case ($urandom_range(0, 2))
                            0:       ch[c] = 8'h00;
                            1:       ch[c] = 8'hFF;
                            default: ch[c] = 8'($urandom_range(0, 255));
                        endcase
                    else
                        ch[c] = 8'($urandom_range(0, 255));
                end
                px = {ch[0], ch[1], ch[2], ch[3]};
                send_pixel(px, pick_gap(quiet), 1'b0, '0);
                sent++;
                random_items++;
            end
        end

        // Drain and report
        settle_block();
        if (expected_px.size() != 0)
        begin
            $display("%0d expected results never arrived", expected_px.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/hsd_pkg.sv
rtl/hsd_ifs.sv
rtl/hsd_front.sv
rtl/hsd_accum.sv
rtl/hsd_encode.sv
rtl/half_scale_rgba_downsampler.sv
test/tb_top.sv
